// ----- rtl/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types, constants and helpers for the telemetry frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int PAYLOAD_BYTES = 28;
  localparam int IDX_W         = 5;               // payload byte index
  localparam int BANKS         = 2;
  localparam int RAM_DEPTH     = BANKS * (1 << IDX_W);
  localparam int NUM_FIELDS    = 16;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFE;
  localparam logic [7:0]  LEN_BYTE   = 8'(PAYLOAD_BYTES);
  localparam logic [7:0]  CMD_TELEM  = 8'h25;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [IDX_W-1:0] IDX_CMD    = '0;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(PAYLOAD_BYTES - 2);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PAYLOAD_BYTES - 1);

  localparam logic [3:0] FID_FIRST_U8  = 4'd3;
  localparam logic [3:0] FID_FIRST_I16 = 4'd7;
  localparam logic [3:0] FID_LAST      = 4'(NUM_FIELDS - 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_CMD = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  // one frame report waiting for the back end
  typedef struct packed {
    logic [1:0] status;
    logic       bank;
  } job_t;

  // back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // payload index of the (first) byte of a field
  function automatic logic [IDX_W-1:0] field_idx(input logic [3:0] id);
    logic [IDX_W-1:0] r;
    if (id < FID_FIRST_I16) begin
      r = {1'b0, id} + IDX_W'(1);
    end else begin
      r = {id, 1'b0} - IDX_W'(6);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] field_decode(input logic [1:0] status,
                                                      input logic [3:0] id,
                                                      input logic [7:0] hi,
                                                      input logic [7:0] lo);
    logic signed [15:0] v;
    if (status != ST_OK) begin
      v = '0;
    end else if (id < FID_FIRST_U8) begin
      v = {{8{hi[7]}}, hi};
    end else if (id < FID_FIRST_I16) begin
      v = {8'h00, hi};
    end else begin
      v = {hi, lo};
    end
    return v;
  endfunction

endpackage

// ----- rtl/tfp_ram.sv -----
// ----------------------------------------------------------------------------
// tfp_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// ----------------------------------------------------------------------------
module tfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/tfp_queue.sv -----
// ----------------------------------------------------------------------------
// tfp_queue
// Two-entry job queue between the frame front end and the result back end.
// ----------------------------------------------------------------------------
module tfp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tfp_pkg::job_t push_job,
  input  logic          pop,
  output tfp_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  tfp_pkg::job_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign head  = slots[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/tfp_front.sv -----
// ----------------------------------------------------------------------------
// tfp_front
// Byte front end: sync hunt, length check, CRC, payload capture into a
// buffer bank, and one job per frame report into the queue.
// ----------------------------------------------------------------------------
module tfp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rx_valid,
  input  logic [7:0]                      rx_byte,
  output logic                            rx_stall,
  input  logic                            q_full,
  output logic                            push,
  output tfp_pkg::job_t                   push_job,
  input  tfp_pkg::rel_t                   rel,
  output logic                            ram_we,
  output logic [tfp_pkg::IDX_W:0]         ram_waddr,
  output logic [7:0]                      ram_wdata
);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  logic [1:0]                phase;
  logic [1:0]                phase_next;
  logic [tfp_pkg::IDX_W-1:0] byte_count;
  logic [tfp_pkg::IDX_W-1:0] byte_count_next;
  logic [15:0]               crc_acc;
  logic [15:0]               crc_acc_next;
  logic                      cmd_ok;
  logic [7:0]                crc_hi;
  logic                      wbank;
  logic [1:0]                bank_busy;
  logic                      accept;
  logic [15:0]               crc_upd;
  logic [1:0]                frame_status;

  // hold input while the queue is full or the fill bank is still draining
  assign rx_stall = q_full | bank_busy[wbank];
  assign accept   = rx_valid & ~rx_stall;

  assign crc_upd = tfp_pkg::crc16_update((phase == PH_HUNT1) ? tfp_pkg::CRC_INIT : crc_acc,
                                         rx_byte);

  assign ram_we    = accept && (phase == PH_DATA);
  assign ram_waddr = {wbank, byte_count};
  assign ram_wdata = rx_byte;

  always_comb begin
    if (!cmd_ok) begin
      frame_status = tfp_pkg::ST_BAD_CMD;
    end else if ({crc_hi, rx_byte} != crc_acc) begin
      frame_status = tfp_pkg::ST_BAD_CRC;
    end else begin
      frame_status = tfp_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    crc_acc_next    = crc_acc;
    push            = 1'b0;
    push_job.status = tfp_pkg::ST_BAD_LEN;
    push_job.bank   = wbank;
    if (accept) begin
      case (phase)
        PH_HUNT1: begin
          if (rx_byte == tfp_pkg::SYNC_BYTE) begin
            crc_acc_next = crc_upd;
            phase_next   = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (rx_byte == tfp_pkg::SYNC_BYTE) begin
            crc_acc_next = crc_upd;
            phase_next   = PH_LEN;
          end else begin
            crc_acc_next = tfp_pkg::CRC_INIT;
            phase_next   = PH_HUNT1;
          end
        end
        PH_LEN: begin
          if (rx_byte != tfp_pkg::LEN_BYTE) begin
            push         = 1'b1;
            crc_acc_next = tfp_pkg::CRC_INIT;
            phase_next   = PH_HUNT1;
          end else begin
            crc_acc_next    = crc_upd;
            byte_count_next = '0;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (byte_count < tfp_pkg::IDX_CRC_HI) begin
            crc_acc_next = crc_upd;
          end
          if (byte_count != tfp_pkg::IDX_LAST) begin
            byte_count_next = byte_count + 1'b1;
          end else begin
            push            = 1'b1;
            push_job.status = frame_status;
            byte_count_next = '0;
            crc_acc_next    = tfp_pkg::CRC_INIT;
            phase_next      = PH_HUNT1;
          end
        end
        default: begin
          phase_next = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA) begin
      if (byte_count == tfp_pkg::IDX_CMD) begin
        cmd_ok <= (rx_byte == tfp_pkg::CMD_TELEM);
      end
      if (byte_count == tfp_pkg::IDX_CRC_HI) begin
        crc_hi <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      byte_count <= '0;
      crc_acc    <= tfp_pkg::CRC_INIT;
      wbank      <= 1'b0;
      bank_busy  <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      crc_acc    <= crc_acc_next;
      // a good frame locks its bank until the back end has read it out
      if (push && push_job.status == tfp_pkg::ST_OK) begin
        bank_busy[wbank] <= 1'b1;
        wbank            <= ~wbank;
      end
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/tfp_back.sv -----
// ----------------------------------------------------------------------------
// tfp_back
// Result back end: turns each job into one error word or 16 field words,
// reading the payload bank through the RAM's two read ports.
// ----------------------------------------------------------------------------
module tfp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  tfp_pkg::job_t           head,
  input  logic                    q_empty,
  output logic                    pop,
  output tfp_pkg::rel_t           rel,
  output logic                    ram_re,
  output logic [tfp_pkg::IDX_W:0] ram_raddr_a,
  output logic [tfp_pkg::IDX_W:0] ram_raddr_b,
  input  logic [7:0]              ram_rdata_a,
  input  logic [7:0]              ram_rdata_b,
  output logic                    fld_valid,
  input  logic                    fld_stall,
  output logic [1:0]              status,
  output logic [3:0]              field_id,
  output logic signed [15:0]      field_value,
  output logic                    last
);

  logic                      out_ready;
  logic                      s1_free;
  logic                      issue;
  logic                      is_err;
  logic                      final_word;
  logic [3:0]                fcnt;
  logic [tfp_pkg::IDX_W-1:0] idx_hi;
  // stage 1: RAM read in flight, metadata alongside
  logic                      s1_valid;
  logic [1:0]                s1_status;
  logic [3:0]                s1_id;
  logic                      s1_last;

  assign out_ready  = ~fld_valid | ~fld_stall;
  assign s1_free    = ~s1_valid | out_ready;
  assign issue      = s1_free & ~q_empty;
  assign is_err     = (head.status != tfp_pkg::ST_OK);
  assign final_word = is_err || (fcnt == tfp_pkg::FID_LAST);
  assign pop        = issue & final_word;

  assign rel.valid = issue & ~is_err & (fcnt == tfp_pkg::FID_LAST);
  assign rel.bank  = head.bank;

  assign idx_hi      = tfp_pkg::field_idx(fcnt);
  assign ram_re      = issue;
  assign ram_raddr_a = {head.bank, idx_hi};
  assign ram_raddr_b = {head.bank, idx_hi + 1'b1};

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_status <= head.status;
      s1_id     <= is_err ? 4'd0 : fcnt;
      s1_last   <= final_word;
    end
    if (out_ready && s1_valid) begin
      status      <= s1_status;
      field_id    <= s1_id;
      field_value <= tfp_pkg::field_decode(s1_status, s1_id, ram_rdata_a, ram_rdata_b);
      last        <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt      <= '0;
      s1_valid  <= 1'b0;
      fld_valid <= 1'b0;
    end else begin
      if (pop) begin
        fcnt <= '0;
      end else if (issue) begin
        fcnt <= fcnt + 1'b1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_ready) begin
        s1_valid <= 1'b0;
      end
      if (out_ready) begin
        fld_valid <= s1_valid;
      end
    end
  end

endmodule

// ----- rtl/telemetry_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// telemetry_frame_parser_top
// Serial telemetry frame parser with CRC-16/MODBUS check and field decode.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on rx while rx_stall is low. Frames are
// FE FE 1C, then 28 payload bytes (command 0x25, 25 data bytes, CRC high byte
// first). A bad length word is reported as soon as the length byte arrives; a
// bad command or CRC is reported when the last CRC byte arrives; a good frame
// yields 16 field words with last set on the final one. Payload goes into one
// of two RAM banks, so a new frame is received while the previous one drains at
// one word per cycle while fld_stall is low. With the back end idle, once the
// byte that completes a report is taken, its first word passes through the
// queue register, the RAM read with its stage-1 metadata register, and then the
// output register. rx stalls when the two-entry report queue is full or the
// bank it would fill next is still being read out. An error report is a single
// word and a good frame's report 16 words, so the queue can fill even with fld
// never held, e.g. when short bad-length reports closely follow a good frame.
module telemetry_frame_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               fld_valid,
  input  logic               fld_stall,
  output logic [1:0]         status,
  output logic [3:0]         field_id,
  output logic signed [15:0] field_value,
  output logic               last
);

  tfp_pkg::job_t           push_job;
  tfp_pkg::job_t           head;
  tfp_pkg::rel_t           rel;
  logic                    push;
  logic                    pop;
  logic                    q_empty;
  logic                    q_full;
  logic                    ram_we;
  logic [tfp_pkg::IDX_W:0] ram_waddr;
  logic [7:0]              ram_wdata;
  logic                    ram_re;
  logic [tfp_pkg::IDX_W:0] ram_raddr_a;
  logic [tfp_pkg::IDX_W:0] ram_raddr_b;
  logic [7:0]              ram_rdata_a;
  logic [7:0]              ram_rdata_b;

  tfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_byte   (rx_byte),
    .rx_stall  (rx_stall),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  tfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tfp_ram #(
    .WIDTH (8),
    .DEPTH (tfp_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  tfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .rel         (rel),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .fld_valid   (fld_valid),
    .fld_stall   (fld_stall),
    .status      (status),
    .field_id    (field_id),
    .field_value (field_value),
    .last        (last)
  );

  // no push into a full report queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("report queue overflow");

  // an error report is a single zeroed word
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    fld_valid && status != tfp_pkg::ST_OK |-> last && field_id == 4'd0 && field_value == 16'sd0)
    else $error("malformed error word");

  // a good frame ends on its final field
  a_ok_last: assert property (@(posedge clk) disable iff (rst)
    fld_valid && status == tfp_pkg::ST_OK |-> last == (field_id == tfp_pkg::FID_LAST))
    else $error("last flag out of place");

  // a bank is handed back only by the word that pops its job
  a_rel_pop: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> pop)
    else $error("bank released without pop");

endmodule
